// ----- rtl/bcc_pkg.sv -----
// Shared types, codes and reset values for the button click classifier.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package bcc_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned ClicksW = 2;
  localparam int unsigned EventW  = 3;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CountW-1:0]  CountMax  = {CountW{1'b1}};
  localparam logic [ClicksW-1:0] ClicksMax = {ClicksW{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegDebounce = 8'd0;
  localparam logic [CfgIdxW-1:0] RegShort    = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLong     = 8'd2;
  localparam logic [CfgIdxW-1:0] RegWindow   = 8'd3;

  // Register reset values
  localparam logic [CountW-1:0] DebounceReset = 16'd20;
  localparam logic [CountW-1:0] ShortReset    = 16'd200;
  localparam logic [CountW-1:0] LongReset     = 16'd600;
  localparam logic [CountW-1:0] WindowReset   = 16'd300;

  // Event codes
  localparam logic [EventW-1:0] EvNone   = 3'd0;
  localparam logic [EventW-1:0] EvShort  = 3'd1;
  localparam logic [EventW-1:0] EvLong   = 3'd2;
  localparam logic [EventW-1:0] EvDouble = 3'd3;
  localparam logic [EventW-1:0] EvTriple = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_PRESSED  = 5'b00100,
    PH_HOLD     = 5'b01000,
    PH_WAIT     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CountW-1:0] debounce_ticks;
    logic [CountW-1:0] short_press_limit;
    logic [CountW-1:0] long_press_ticks;
    logic [CountW-1:0] click_window_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [CountW-1:0]  tick_count;
    logic [ClicksW-1:0] clicks;
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/button_click_classifier.sv -----
// Button click classifier, top level: sample register, state registers, event register.
// Depends on bcc_pkg, bcc_cfg and bcc_step.
`default_nettype none

// One item on the sample channel is one tick of the debounced-button clock: the
// sampled level of an active-high button. Every accepted sample yields exactly
// one item on the event channel, in order: 0 none, 1 single click, 2 long press,
// 3 double click, 4 triple click. A press must hold for debounce_ticks to count;
// a hold reaching long_press_ticks reports a long press once; releases before
// short_press_limit are gathered as clicks (saturating at three) and reported
// once click_window_ticks pass with no new press. A release between the short
// and long limits is dropped without an event.
// Timing: a sample is registered on acceptance, processed by the state update
// and lands in the event register; one sample can be taken every cycle while
// the event register is not held by event_stall. The event register holds a
// result while event_stall is high; the sample register then fills and
// sample_stall rises. Configuration registers (index 0 debounce, 1 short limit,
// 2 long press, 3 click window; other indexes ignored) are always ready and
// should only be written with no samples in flight.

module button_click_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // sample channel
  input  wire logic                        sample_valid,
  output logic                             sample_stall,
  input  wire logic                        pressed,
  // event channel
  output logic                             event_valid,
  input  wire logic                        event_stall,
  output logic [bcc_pkg::EventW-1:0]       event_code,
  // configuration write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bcc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bcc_pkg::CountW-1:0]  cfg_data
);

  bcc_pkg::cfg_t   cfg;
  bcc_pkg::state_t state;
  bcc_pkg::state_t state_next;
  logic [bcc_pkg::EventW-1:0] event_next;

  logic s1_valid;
  logic s1_pressed;
  logic advance;   // event register free to take the next result
  logic take;      // sample accepted this cycle

  assign cfg_ready    = 1'b1;
  assign advance      = !event_valid || !event_stall;
  assign sample_stall = s1_valid && !advance;
  assign take         = sample_valid && !sample_stall;

  bcc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bcc_step u_step (
    .cur        (state),
    .cfg        (cfg),
    .pressed    (s1_pressed),
    .nxt        (state_next),
    .event_next (event_next)
  );

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pressed <= pressed;
    end
  end

  // classifier state: moves only when a sample goes through to the event register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= bcc_pkg::PH_IDLE;
      state.tick_count <= '0;
      state.clicks     <= '0;
    end else if (s1_valid && advance) begin
      state <= state_next;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      event_code <= event_next;
    end
  end

  // A processed sample always leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> event_valid)
    else $error("processed sample left no event");

  // A sample blocked by the event register stays put.
  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    sample_stall |=> (s1_valid && $stable(s1_pressed)))
    else $error("blocked sample lost");

  // Any phase past debounce carries at least one click.
  a_clicks_live: assert property (@(posedge clk) disable iff (rst)
    (state.phase == bcc_pkg::PH_PRESSED || state.phase == bcc_pkg::PH_HOLD ||
     state.phase == bcc_pkg::PH_WAIT) |-> (state.clicks != '0))
    else $error("no click counted in an active phase");

  // Idle always starts from a cleared timer.
  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (state.phase == bcc_pkg::PH_IDLE) |-> (state.tick_count == '0))
    else $error("timer not cleared in idle");

endmodule

`default_nettype wire

// ----- rtl/bcc_cfg.sv -----
// Configuration register file: four 16-bit thresholds, written one at a time.
// Depends on bcc_pkg.
`default_nettype none

module bcc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [bcc_pkg::CfgIdxW-1:0] wr_index,
  input  wire logic [bcc_pkg::CountW-1:0]  wr_data,
  output bcc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= bcc_pkg::DebounceReset;
      cfg.short_press_limit  <= bcc_pkg::ShortReset;
      cfg.long_press_ticks   <= bcc_pkg::LongReset;
      cfg.click_window_ticks <= bcc_pkg::WindowReset;
    end else if (wr_en) begin
      case (wr_index)
        bcc_pkg::RegDebounce: cfg.debounce_ticks     <= wr_data;
        bcc_pkg::RegShort:    cfg.short_press_limit  <= wr_data;
        bcc_pkg::RegLong:     cfg.long_press_ticks   <= wr_data;
        bcc_pkg::RegWindow:   cfg.click_window_ticks <= wr_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcc_step.sv -----
// Next-state and event logic for one tick of the click classifier.
// Purely combinational; depends on bcc_pkg.
`default_nettype none

module bcc_step (
  input  wire bcc_pkg::state_t            cur,
  input  wire bcc_pkg::cfg_t              cfg,
  input  wire logic                       pressed,
  output bcc_pkg::state_t                 nxt,
  output logic [bcc_pkg::EventW-1:0]      event_next
);

  logic [bcc_pkg::CountW-1:0] cnt_inc;
  logic [bcc_pkg::EventW-1:0] click_ev;

  // saturating tick counter
  assign cnt_inc = (cur.tick_count != bcc_pkg::CountMax) ?
                   cur.tick_count + 1'b1 : cur.tick_count;

  always_comb begin
    case (cur.clicks)
      2'd0:    click_ev = bcc_pkg::EvNone;
      2'd1:    click_ev = bcc_pkg::EvShort;
      2'd2:    click_ev = bcc_pkg::EvDouble;
      default: click_ev = bcc_pkg::EvTriple;
    endcase
  end

  always_comb begin
    nxt        = cur;
    event_next = bcc_pkg::EvNone;
    case (cur.phase)
      bcc_pkg::PH_IDLE: begin
        if (pressed) begin
          nxt.phase      = bcc_pkg::PH_DEBOUNCE;
          nxt.tick_count = '0;
        end
      end
      bcc_pkg::PH_DEBOUNCE: begin
        nxt.tick_count = cnt_inc;
        if (pressed) begin
          if (cnt_inc >= cfg.debounce_ticks) begin
            nxt.phase      = bcc_pkg::PH_PRESSED;
            nxt.tick_count = '0;
            if (cur.clicks != bcc_pkg::ClicksMax) nxt.clicks = cur.clicks + 1'b1;
          end
        end else begin
          nxt.phase      = bcc_pkg::PH_IDLE;
          nxt.tick_count = '0;
        end
      end
      bcc_pkg::PH_PRESSED: begin
        nxt.tick_count = cnt_inc;
        if (!pressed) begin
          if (cnt_inc < cfg.short_press_limit) begin
            nxt.phase = bcc_pkg::PH_WAIT;
          end else begin
            nxt.phase  = bcc_pkg::PH_IDLE;
            nxt.clicks = '0;
          end
          nxt.tick_count = '0;
        end else if (cnt_inc >= cfg.long_press_ticks) begin
          event_next = bcc_pkg::EvLong;
          nxt.phase  = bcc_pkg::PH_HOLD;
        end
      end
      bcc_pkg::PH_HOLD: begin
        if (!pressed) begin
          nxt.phase      = bcc_pkg::PH_IDLE;
          nxt.tick_count = '0;
          nxt.clicks     = '0;
        end
      end
      bcc_pkg::PH_WAIT: begin
        nxt.tick_count = cnt_inc;
        if (pressed) begin
          if (cnt_inc >= cfg.click_window_ticks) begin
            event_next = click_ev;
            nxt.clicks = '0;
          end
          nxt.phase      = bcc_pkg::PH_DEBOUNCE;
          nxt.tick_count = '0;
        end else if (cnt_inc >= cfg.click_window_ticks) begin
          event_next     = click_ev;
          nxt.phase      = bcc_pkg::PH_IDLE;
          nxt.tick_count = '0;
          nxt.clicks     = '0;
        end
      end
      default: begin
        nxt.phase = bcc_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/button_click_classifier_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for button_click_classifier: button samples in, one event out per sample.
// Depends on bcc_pkg and the RTL top only; predicts every event and compares in order.

module button_click_classifier_tb;

  localparam int GapMax       = 18;        // longest sender gap / receiver stall
  localparam int PhaseTicks   = 200;       // samples per random register setting
  localparam int RandomPhases = 10;
  localparam int LenCap       = 800;       // longest run of one level in a gesture
  localparam int ReportMax    = 10;
  localparam int CycleLimit   = 2_000_000;

  // ---------------------------------------------------------------------------
  // DUT connections; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         sample_valid = 1'b0;
  logic                         sample_stall;
  logic                         pressed      = 1'b0;
  logic                         event_valid;
  logic                         event_stall  = 1'b0;
  logic [bcc_pkg::EventW-1:0]   event_code;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [bcc_pkg::CfgIdxW-1:0]  cfg_index    = '0;
  logic [bcc_pkg::CountW-1:0]   cfg_data     = '0;

  button_click_classifier i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pressed      (pressed),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_code   (event_code),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench-side copy of the classifier: thresholds and machine state
  // ---------------------------------------------------------------------------
  bcc_pkg::cfg_t               thr      = {bcc_pkg::DebounceReset, bcc_pkg::ShortReset,
                                           bcc_pkg::LongReset, bcc_pkg::WindowReset};
  bcc_pkg::phase_t             phase_q  = bcc_pkg::PH_IDLE;
  logic [bcc_pkg::CountW-1:0]  tick_q   = '0;
  logic [bcc_pkg::ClicksW-1:0] clicks_q = '0;

  logic [bcc_pkg::EventW-1:0]  pending_events [$];   // events owed by the DUT, oldest first

  int sample_gap_max = GapMax;
  int stall_max      = GapMax;
  int ticks_sent     = 0;
  int phase_ticks    = 0;
  int events_checked = 0;
  int mismatches     = 0;
  int settings_used  = 0;
  int reg_writes     = 0;
  int events_seen [0:4] = '{default: 0};

  // Event owed for the clicks gathered so far once the window closes
  function automatic logic [bcc_pkg::EventW-1:0] click_report();
    case (clicks_q)
      2'd1:    return bcc_pkg::EvShort;
      2'd2:    return bcc_pkg::EvDouble;
      2'd3:    return bcc_pkg::EvTriple;
      default: return bcc_pkg::EvNone;
    endcase
  endfunction

  // Advances the machine by one sample and gives that sample's event
  task automatic classify_tick(input logic btn, output logic [bcc_pkg::EventW-1:0] ev);
    ev = bcc_pkg::EvNone;
    case (phase_q)
      bcc_pkg::PH_IDLE: begin
        if (btn) begin
          phase_q = bcc_pkg::PH_DEBOUNCE;
          tick_q  = '0;
        end
      end
      bcc_pkg::PH_DEBOUNCE: begin
        if (tick_q != bcc_pkg::CountMax) tick_q++;
        if (btn) begin
          if (tick_q >= thr.debounce_ticks) begin
            phase_q = bcc_pkg::PH_PRESSED;
            tick_q  = '0;
            if (clicks_q != bcc_pkg::ClicksMax) clicks_q++;
          end
        end else begin
          phase_q = bcc_pkg::PH_IDLE;
          tick_q  = '0;
        end
      end
      bcc_pkg::PH_PRESSED: begin
        if (tick_q != bcc_pkg::CountMax) tick_q++;
        if (!btn) begin
          // short release joins the sequence; a mid-length one is dropped
          if (tick_q < thr.short_press_limit) begin
            phase_q = bcc_pkg::PH_WAIT;
          end else begin
            phase_q  = bcc_pkg::PH_IDLE;
            clicks_q = '0;
          end
          tick_q = '0;
        end else if (tick_q >= thr.long_press_ticks) begin
          ev      = bcc_pkg::EvLong;
          phase_q = bcc_pkg::PH_HOLD;
        end
      end
      bcc_pkg::PH_HOLD: begin
        // earlier clicks vanish with the long press, no event
        if (!btn) begin
          phase_q  = bcc_pkg::PH_IDLE;
          tick_q   = '0;
          clicks_q = '0;
        end
      end
      bcc_pkg::PH_WAIT: begin
        if (tick_q != bcc_pkg::CountMax) tick_q++;
        if (btn) begin
          // late press: report what was gathered, then start afresh
          if (tick_q >= thr.click_window_ticks) begin
            ev       = click_report();
            clicks_q = '0;
          end
          phase_q = bcc_pkg::PH_DEBOUNCE;
          tick_q  = '0;
        end else if (tick_q >= thr.click_window_ticks) begin
          ev       = click_report();
          phase_q  = bcc_pkg::PH_IDLE;
          tick_q   = '0;
          clicks_q = '0;
        end
      end
      default: phase_q = bcc_pkg::PH_IDLE;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sample side. Called and left at a falling edge; valid only drops when a
  // gap is drawn, so back-to-back items keep it high with no glitch.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic level, input logic typed,
                           input logic [bcc_pkg::EventW-1:0] code);
    int                         gap;
    logic [bcc_pkg::EventW-1:0] ev;
    gap = (sample_gap_max == 0) ? 0 : $urandom_range(0, sample_gap_max);
    if (gap != 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid = 1'b1;
    pressed      = level;
    do @(posedge clk); while (sample_stall);
    // accepted: keep the predictor in step, but trust a typed-in value
    classify_tick(level, ev);
    pending_events.push_back(typed ? code : ev);
    ticks_sent++;
    phase_ticks++;
    @(negedge clk);
  endtask

  task automatic send_level(input logic level, input int n);
    repeat (n) send_tick(level, 1'b0, bcc_pkg::EvNone);
  endtask

  // Drains the pipe so register writes land between samples only
  task automatic wait_idle();
    sample_valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bcc_pkg::CfgIdxW-1:0] idx,
                           input logic [bcc_pkg::CountW-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bcc_pkg::RegDebounce: thr.debounce_ticks     = val;
      bcc_pkg::RegShort:    thr.short_press_limit  = val;
      bcc_pkg::RegLong:     thr.long_press_ticks   = val;
      bcc_pkg::RegWindow:   thr.click_window_ticks = val;
      default:              ;   // unmapped index, ignored by the block
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Full register set plus one write to an unmapped index
  task automatic set_thresholds(input logic [bcc_pkg::CountW-1:0] db,
                                input logic [bcc_pkg::CountW-1:0] sh,
                                input logic [bcc_pkg::CountW-1:0] lg,
                                input logic [bcc_pkg::CountW-1:0] wn);
    wait_idle();
    write_reg(bcc_pkg::RegDebounce, db);
    write_reg(bcc_pkg::RegShort, sh);
    write_reg(bcc_pkg::RegLong, lg);
    write_reg(bcc_pkg::RegWindow, wn);
    write_reg(bcc_pkg::CfgIdxW'($urandom_range(4, 255)), bcc_pkg::CountW'($urandom));
    settings_used++;
    phase_ticks = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Gesture lengths, drawn around the live thresholds
  // ---------------------------------------------------------------------------
  function automatic int press_len();
    int acc;
    int n;
    // samples from the first high one to acceptance of the press
    acc = ((thr.debounce_ticks == 0) ? 1 : int'(thr.debounce_ticks)) + 1;
    case ($urandom_range(0, 7))
      0:       n = $urandom_range(1, acc);                               // bounce
      1, 2, 3: n = acc + $urandom_range(0, thr.short_press_limit + 1);   // click
      4, 5:    n = acc + thr.short_press_limit - 2 + $urandom_range(0, 4);
      default: n = acc + thr.long_press_ticks - 2 + $urandom_range(0, 5);
    endcase
    if (n > LenCap) n = $urandom_range(1, 40);
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic int release_len();
    int wn;
    int n;
    wn = thr.click_window_ticks;
    case ($urandom_range(0, 3))
      0, 1:    n = $urandom_range(1, (wn > 1) ? wn - 1 : 1);   // keep the sequence going
      2:       n = wn - 1 + $urandom_range(0, 2);              // right on the window
      default: n = wn + $urandom_range(1, 10);
    endcase
    if (n > LenCap) n = $urandom_range(1, 20);
    if (n < 1) n = 1;
    return n;
  endfunction

  // Mostly press/release pairs; one in ten is plain level noise
  task automatic run_gesture();
    sample_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GapMax;
    stall_max      = ($urandom_range(0, 3) == 0) ? 0 : GapMax;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8))
        send_tick(1'($urandom_range(0, 1)), 1'b0, bcc_pkg::EvNone);
    end else begin
      send_level(1'b1, press_len());
      send_level(1'b0, release_len());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Event side: random stall before each item, then in-order compare
  // ---------------------------------------------------------------------------
  task automatic check_event(input logic [bcc_pkg::EventW-1:0] got);
    logic [bcc_pkg::EventW-1:0] want;
    if (pending_events.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("[%0t] event %0d arrived with nothing outstanding", $realtime, got);
    end else begin
      want = pending_events.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("[%0t] event #%0d: expected %0d, got %0d",
                   $realtime, events_checked, want, got);
      end else begin
        events_seen[got]++;
      end
    end
    events_checked++;
  endtask

  initial begin
    int stall_len;
    wait (rst == 1'b0);
    forever begin
      stall_len = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      if (stall_len != 0) begin
        event_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      event_stall = 1'b0;
      do @(posedge clk); while (!event_valid);
      check_event(event_code);
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d events outstanding",
             CycleLimit, pending_events.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed walk, run with debounce 1, short limit 2, long press 4, window 2.
  // Typed codes are the ones that can be read straight off the sequence:
  //   rows 1-13  four quick clicks, count pinned at three
  //   row 14     late press after the window: triple reported on the press
  //   rows 15-19 that press held to the long limit, long press on row 19
  //   row 20     release out of long hold, silent
  //   rows 21-24 release between short and long limits, dropped silently
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                       level;
    logic                       typed;
    logic [bcc_pkg::EventW-1:0] code;
  } tick_row_t;

  tick_row_t dir_rows [25] = '{
    '{1'b0, 1'b1, bcc_pkg::EvNone},     // straight out of reset
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b0, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b0, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b0, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b0, 1'b0, bcc_pkg::EvNone},
    '{1'b0, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b1, bcc_pkg::EvTriple},
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b1, bcc_pkg::EvLong},
    '{1'b0, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b0, bcc_pkg::EvNone}, '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b1, 1'b0, bcc_pkg::EvNone},
    '{1'b0, 1'b1, bcc_pkg::EvNone}
  };

  initial begin
    int p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_thresholds(16'd1, 16'd2, 16'd4, 16'd2);
    foreach (dir_rows[r]) send_tick(dir_rows[r].level, dir_rows[r].typed, dir_rows[r].code);

    // Random phases: reset values, all zero, all max, a lopsided mix, then
    // small random settings where every event comes up often.
    for (p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       set_thresholds(bcc_pkg::DebounceReset, bcc_pkg::ShortReset,
                                bcc_pkg::LongReset, bcc_pkg::WindowReset);
        1:       set_thresholds('0, '0, '0, '0);
        2:       set_thresholds(bcc_pkg::CountMax, bcc_pkg::CountMax,
                                bcc_pkg::CountMax, bcc_pkg::CountMax);
        3:       set_thresholds('0, bcc_pkg::CountMax, 16'd1, bcc_pkg::CountMax);
        default: set_thresholds(bcc_pkg::CountW'($urandom_range(0, 6)),
                                bcc_pkg::CountW'($urandom_range(0, 12)),
                                bcc_pkg::CountW'($urandom_range(0, 20)),
                                bcc_pkg::CountW'($urandom_range(0, 8)));
      endcase
      while (phase_ticks < PhaseTicks) run_gesture();
    end

    // One long hold with the short limit at its top, no idling
    set_thresholds(16'd1, bcc_pkg::CountMax, 16'd300, 16'd3);
    sample_gap_max = 0;
    stall_max      = 0;
    send_level(1'b1, 304);
    send_level(1'b0, 6);

    wait_idle();
    $display("Sent %0d samples over %0d register settings (%0d register writes)",
             ticks_sent, settings_used, reg_writes);
    $display("Matched events: %0d single, %0d double, %0d triple, %0d long, %0d mismatches",
             events_seen[bcc_pkg::EvShort], events_seen[bcc_pkg::EvDouble],
             events_seen[bcc_pkg::EvTriple], events_seen[bcc_pkg::EvLong], mismatches);
    if (mismatches == 0 && pending_events.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- button_click_classifier.f -----
rtl/bcc_pkg.sv
rtl/bcc_cfg.sv
rtl/bcc_step.sv
rtl/button_click_classifier.sv
verif/button_click_classifier_tb.sv
